// ----- src/skvt_pkg.sv -----
package skvt_pkg;

	typedef enum logic [1:0] {
		REQ_SET  = 2'd0,
		REQ_GET  = 2'd1,
		REQ_SORT = 2'd2
	} req_code_t;

	typedef enum logic [2:0] {
		RS_INSERTED    = 3'd0,
		RS_REPLACED    = 3'd1,
		RS_FULL        = 3'd2,
		RS_FOUND       = 3'd3,
		RS_NOT_FOUND   = 3'd4,
		RS_SORTED      = 3'd5,
		RS_NOT_ORDERED = 3'd6
	} rsp_status_t;

	typedef struct packed {
		req_code_t          req_type;
		logic signed [63:0] key;
		logic [63:0]        value;
		logic [1:0]         value_type;
	} req_t;

	typedef struct packed {
		rsp_status_t status;
		logic [6:0]  index;
		logic [63:0] stored_value;
		logic [1:0]  stored_type;
		logic        type_match;
		logic [6:0]  entry_total;
	} rsp_t;

	typedef struct packed {
		logic signed [63:0] key;
		logic [63:0]        value;
		logic [1:0]         vtype;
	} entry_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_SEARCH,
		CS_SRCH_CMP,
		CS_DECIDE,
		CS_SHIFT_RD,
		CS_SHIFT_WR,
		CS_INS_WR,
		CS_SORT_RD,
		CS_SORT_LD,
		CS_SORT_JRD,
		CS_SORT_JCMP,
		CS_SORT_PUT,
		CS_RESP
	} ctl_state_t;

	typedef struct packed {
		logic        capture;
		logic        srch_rd;
		logic        srch_upd;
		logic        wr_hit;
		logic        shift_rd;
		logic        shift_wr;
		logic        ins_wr;
		logic        sort_init;
		logic        sort_rd;
		logic        sort_ld;
		logic        sort_jrd;
		logic        sort_jwr;
		logic        sort_put;
		logic        rsp_load;
		rsp_status_t status;
	} ctl_cmd_t;

	typedef struct packed {
		req_code_t req_type;
		logic      searching;
		logic      srch_go;
		logic      srch_more;
		logic      hit;
		logic      full;
		logic      shift_needed;
		logic      i_lt_count;
		logic      j_zero;
		logic      sort_gt;
		logic      rsp_busy;
	} dp_stat_t;

endpackage

// ----- src/skvt_datapath.sv -----
module skvt_datapath import skvt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic     cfg_wr_data,
	input  req_t     req,
	output rsp_t     rsp,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	entry_t        mem_q [TABLE_DEPTH];
	entry_t        rd_q;
	entry_t        tmp_q;
	req_t          req_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic          mode_q;
	logic          sorted_q;
	logic          hit_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;

	logic [CW-1:0] mid;
	logic [CW-1:0] nlo;
	logic [CW-1:0] nhi;
	logic          key_eq;
	logic          key_lt;
	logic          searching;
	logic          rd_en;
	logic [CW-1:0] rd_addr;
	logic          wr_en;
	logic [CW-1:0] wr_addr;
	entry_t        wr_data;
	logic          found;

	assign searching = mode_q | sorted_q;
	assign mid       = lo_q + ((hi_q - lo_q - CW'(1)) >> 1);
	assign key_eq    = $signed(rd_q.key) == $signed(req_q.key);
	assign key_lt    = $signed(rd_q.key) < $signed(req_q.key);
	assign nlo       = key_lt ? mid + CW'(1) : lo_q;
	assign nhi       = key_lt ? hi_q : mid;

	always_comb begin
		rd_en   = cmd.srch_rd | cmd.shift_rd | cmd.sort_rd | cmd.sort_jrd;
		rd_addr = mid;
		if (cmd.shift_rd) begin
			rd_addr = i_q - CW'(1);
		end else if (cmd.sort_rd) begin
			rd_addr = i_q;
		end else if (cmd.sort_jrd) begin
			rd_addr = j_q - CW'(1);
		end
	end

	always_comb begin
		wr_en   = cmd.wr_hit | cmd.shift_wr | cmd.ins_wr | cmd.sort_jwr | cmd.sort_put;
		wr_addr = lo_q;
		wr_data = '{key: req_q.key, value: req_q.value, vtype: req_q.value_type};
		if (cmd.shift_wr) begin
			wr_addr = i_q;
			wr_data = rd_q;
		end else if (cmd.sort_jwr) begin
			wr_addr = j_q;
			wr_data = rd_q;
		end else if (cmd.sort_put) begin
			wr_addr = j_q;
			wr_data = tmp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.sort_ld) begin
			tmp_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			sorted_q <= 1'b0;
			count_q  <= '0;
			hit_q    <= 1'b0;
			lo_q     <= '0;
			hi_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (cmd.capture) begin
				lo_q  <= searching ? '0 : count_q;
				hi_q  <= count_q;
				i_q   <= count_q;
				hit_q <= 1'b0;
			end
			if (cmd.srch_upd) begin
				if (key_eq) begin
					hit_q <= 1'b1;
					lo_q  <= mid;
				end else begin
					lo_q <= nlo;
					hi_q <= nhi;
				end
			end
			if (cmd.shift_wr) begin
				i_q <= i_q - CW'(1);
			end
			if (cmd.ins_wr) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.sort_init) begin
				i_q      <= CW'(1);
				sorted_q <= 1'b1;
			end
			if (cmd.sort_ld) begin
				j_q <= i_q;
			end
			if (cmd.sort_jwr) begin
				j_q <= j_q - CW'(1);
			end
			if (cmd.sort_put) begin
				i_q <= i_q + CW'(1);
			end
		end
	end

	assign found = cmd.status == RS_FOUND;

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.status       <= cmd.status;
			rsp_q.index        <= (cmd.status == RS_FOUND || cmd.status == RS_REPLACED ||
				cmd.status == RS_INSERTED) ? 7'(lo_q) : 7'd0;
			rsp_q.stored_value <= found ? rd_q.value : 64'd0;
			rsp_q.stored_type  <= found ? rd_q.vtype : 2'd0;
			rsp_q.type_match   <= found && (rd_q.vtype == req_q.value_type);
			rsp_q.entry_total  <= 7'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		stat.req_type     = req_q.req_type;
		stat.searching    = searching;
		stat.srch_go      = (lo_q < hi_q) &&
			(req_q.req_type == REQ_SET || req_q.req_type == REQ_GET);
		stat.srch_more    = !key_eq && (nlo < nhi);
		stat.hit          = hit_q;
		stat.full         = count_q == CW'(TABLE_DEPTH);
		stat.shift_needed = i_q > lo_q;
		stat.i_lt_count   = i_q < count_q;
		stat.j_zero       = j_q == '0;
		stat.sort_gt      = $signed(rd_q.key) > $signed(tmp_q.key);
		stat.rsp_busy     = rsp_valid_q && !rsp_ready;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_addr <= count_q)
		else $error("table write beyond filled region");

	a_sorted_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_q |=> sorted_q)
		else $error("sorted flag dropped");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> !(rsp_valid_q && !rsp_ready))
		else $error("response overwritten before taken");

endmodule

// ----- src/skvt_ctrl.sv -----
module skvt_ctrl import skvt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	ctl_state_t  state_q;
	ctl_state_t  state_d;
	rsp_status_t status_q;
	rsp_status_t status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= CS_IDLE;
			status_q <= RS_NOT_FOUND;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (req_valid) begin
					state_d = CS_SEARCH;
				end
			end
			CS_SEARCH: begin
				state_d = stat.srch_go ? CS_SRCH_CMP : CS_DECIDE;
			end
			CS_SRCH_CMP: begin
				state_d = stat.srch_more ? CS_SEARCH : CS_DECIDE;
			end
			CS_DECIDE: begin
				unique case (stat.req_type)
					REQ_SET: begin
						if (stat.hit || stat.full) begin
							state_d = CS_RESP;
						end else if (stat.shift_needed) begin
							state_d = CS_SHIFT_RD;
						end else begin
							state_d = CS_INS_WR;
						end
					end
					REQ_SORT: state_d = CS_SORT_RD;
					default:  state_d = CS_RESP;
				endcase
			end
			CS_SHIFT_RD:  state_d = CS_SHIFT_WR;
			CS_SHIFT_WR:  state_d = CS_DECIDE;
			CS_INS_WR:    state_d = CS_RESP;
			CS_SORT_RD:   state_d = stat.i_lt_count ? CS_SORT_LD : CS_RESP;
			CS_SORT_LD:   state_d = CS_SORT_JRD;
			CS_SORT_JRD:  state_d = stat.j_zero ? CS_SORT_PUT : CS_SORT_JCMP;
			CS_SORT_JCMP: state_d = stat.sort_gt ? CS_SORT_JRD : CS_SORT_PUT;
			CS_SORT_PUT:  state_d = CS_SORT_RD;
			CS_RESP: begin
				if (!stat.rsp_busy) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		status_d  = status_q;
		unique case (state_q)
			CS_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			CS_SEARCH:   cmd.srch_rd = stat.srch_go;
			CS_SRCH_CMP: cmd.srch_upd = 1'b1;
			CS_DECIDE: begin
				unique case (stat.req_type)
					REQ_SET: begin
						if (stat.hit) begin
							cmd.wr_hit = 1'b1;
							status_d   = RS_REPLACED;
						end else if (stat.full) begin
							status_d = RS_FULL;
						end else begin
							status_d = RS_INSERTED;
						end
					end
					REQ_GET: begin
						if (!stat.searching) begin
							status_d = RS_NOT_ORDERED;
						end else if (stat.hit) begin
							status_d = RS_FOUND;
						end else begin
							status_d = RS_NOT_FOUND;
						end
					end
					REQ_SORT: begin
						cmd.sort_init = 1'b1;
						status_d      = RS_SORTED;
					end
					default: status_d = RS_NOT_FOUND;
				endcase
			end
			CS_SHIFT_RD:  cmd.shift_rd = 1'b1;
			CS_SHIFT_WR:  cmd.shift_wr = 1'b1;
			CS_INS_WR:    cmd.ins_wr = 1'b1;
			CS_SORT_RD:   cmd.sort_rd = stat.i_lt_count;
			CS_SORT_LD:   cmd.sort_ld = 1'b1;
			CS_SORT_JRD:  cmd.sort_jrd = !stat.j_zero;
			CS_SORT_JCMP: cmd.sort_jwr = stat.sort_gt;
			CS_SORT_PUT:  cmd.sort_put = 1'b1;
			CS_RESP:      cmd.rsp_load = !stat.rsp_busy;
			default: ;
		endcase
		cmd.status = status_q;
	end

endmodule

// ----- src/sorted_key_value_table.sv -----
// Key/value table of TABLE_DEPTH entries held in one single-port-read memory, one request
// at a time. In a get, each binary search step is a memory read and a compare. A set of
// a new key runs the search, then shifts entries up one at a time, each move being a read,
// a write and a decide step, and ends with the insert write. A sort is an in-place stable
// insertion sort over the same port. A finished response waits in an output register and
// the next request is taken as soon as the controller is back in idle.
module sorted_key_value_table import skvt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	skvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	skvt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

// ----- tb/sv/skvt_checker.sv -----
module skvt_checker import skvt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   pending,
	output int   fail_count
);

	logic signed [63:0] tbl_key [TABLE_DEPTH];
	logic [63:0]        tbl_val [TABLE_DEPTH];
	logic [1:0]         tbl_type [TABLE_DEPTH];
	int                 tbl_count;
	logic               tbl_sorted;
	logic               ordered_mode;
	rsp_t               rsp_fifo [$];

	assign pending = rsp_fifo.size();

	task automatic key_lookup(input logic signed [63:0] k, output logic found, output int pos);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = tbl_count - 1;
		pos = 0;
		found = 1'b0;
		while (lo <= hi && !found) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_key[mid] == k) begin
				found = 1'b1;
				pos = mid;
			end else if (tbl_key[mid] < k) begin
				lo = mid + 1;
				pos = lo;
			end else begin
				hi = mid - 1;
				pos = mid;
			end
		end
	endtask

	task automatic table_apply(input req_t r, output rsp_t e);
		logic searching;
		logic hit;
		int pos;
		int i;
		int j;
		logic signed [63:0] k;
		logic [63:0] v;
		logic [1:0] t;
		searching = ordered_mode || tbl_sorted;
		hit = 1'b0;
		pos = 0;
		e = '0;
		e.status = RS_NOT_FOUND;
		case (r.req_type)
			REQ_SET: begin
				if (searching) begin
					if (tbl_count > 0)
						key_lookup(r.key, hit, pos);
				end else begin
					pos = tbl_count;
				end
				if (hit) begin
					tbl_val[pos] = r.value;
					tbl_type[pos] = r.value_type;
					e.status = RS_REPLACED;
					e.index = pos[6:0];
				end else if (tbl_count >= TABLE_DEPTH) begin
					e.status = RS_FULL;
				end else begin
					for (i = tbl_count; i > pos; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_val[i] = tbl_val[i-1];
						tbl_type[i] = tbl_type[i-1];
					end
					tbl_key[pos] = r.key;
					tbl_val[pos] = r.value;
					tbl_type[pos] = r.value_type;
					tbl_count++;
					e.status = RS_INSERTED;
					e.index = pos[6:0];
				end
			end
			REQ_GET: begin
				if (!searching) begin
					e.status = RS_NOT_ORDERED;
				end else begin
					if (tbl_count > 0)
						key_lookup(r.key, hit, pos);
					if (hit) begin
						e.status = RS_FOUND;
						e.index = pos[6:0];
						e.stored_value = tbl_val[pos];
						e.stored_type = tbl_type[pos];
						e.type_match = (tbl_type[pos] == r.value_type);
					end
				end
			end
			REQ_SORT: begin
				for (i = 1; i < tbl_count; i++) begin
					k = tbl_key[i];
					v = tbl_val[i];
					t = tbl_type[i];
					j = i;
					while (j > 0 && tbl_key[j-1] > k) begin
						tbl_key[j] = tbl_key[j-1];
						tbl_val[j] = tbl_val[j-1];
						tbl_type[j] = tbl_type[j-1];
						j--;
					end
					tbl_key[j] = k;
					tbl_val[j] = v;
					tbl_type[j] = t;
				end
				tbl_sorted = 1'b1;
				e.status = RS_SORTED;
			end
			default: ;
		endcase
		e.entry_total = tbl_count[6:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			tbl_count = 0;
			tbl_sorted = 1'b0;
			ordered_mode = 1'b1;
			rsp_fifo.delete();
			fail_count = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_fifo.size() == 0) begin
					$display("%0t: response with none expected, actual %p", $time, rsp);
					fail_count++;
				end else begin
					exp_rsp = rsp_fifo.pop_front();
					if (rsp.status !== exp_rsp.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_rsp.status, rsp.status);
						fail_count++;
					end
					if (rsp.index !== exp_rsp.index) begin
						$display("%0t: index expected %0d actual %0d", $time,
							exp_rsp.index, rsp.index);
						fail_count++;
					end
					if (rsp.stored_value !== exp_rsp.stored_value) begin
						$display("%0t: stored_value expected %h actual %h", $time,
							exp_rsp.stored_value, rsp.stored_value);
						fail_count++;
					end
					if (rsp.stored_type !== exp_rsp.stored_type) begin
						$display("%0t: stored_type expected %0d actual %0d", $time,
							exp_rsp.stored_type, rsp.stored_type);
						fail_count++;
					end
					if (rsp.type_match !== exp_rsp.type_match) begin
						$display("%0t: type_match expected %0d actual %0d", $time,
							exp_rsp.type_match, rsp.type_match);
						fail_count++;
					end
					if (rsp.entry_total !== exp_rsp.entry_total) begin
						$display("%0t: entry_total expected %0d actual %0d", $time,
							exp_rsp.entry_total, rsp.entry_total);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en)
				ordered_mode = cfg_wr_data;
			if (req_valid && req_ready) begin
				table_apply(req, exp_rsp);
				rsp_fifo.push_back(exp_rsp);
			end
		end
	end

endmodule

// ----- tb/sv/tb_sorted_key_value_table.sv -----
module tb_sorted_key_value_table;
	import skvt_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	int   pending;
	int   fail_count;
	logic no_idle;
	logic signed [63:0] key_pool [48];

	sorted_key_value_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	skvt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.pending(pending), .fail_count(fail_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#500_000_000;
		$display("sorted_key_value_table verification failed");
		$finish;
	end

	task automatic send_request(input logic [1:0] rt, input logic signed [63:0] k,
			input logic [63:0] v, input logic [1:0] ty);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req.req_type <= req_code_t'(rt);
		req.key <= k;
		req.value <= v;
		req.value_type <= ty;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic set_mode(input logic mode);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int stall;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	initial begin
		logic [1:0] rt;
		logic signed [63:0] k;
		int pick;
		int ph;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		req_valid = 1'b0;
		req = '0;
		no_idle = 1'b0;
		for (int i = 0; i < 48; i++)
			key_pool[i] = $signed({$urandom, $urandom});
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 64'sd0;
		key_pool[3] = -64'sd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unordered appends, duplicate keys, get without search
		set_mode(1'b0);
		send_request(REQ_GET, 64'sd0, '0, 2'd0);
		send_request(REQ_SET, KEY_MAX, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3);
		send_request(REQ_SET, KEY_MIN, 64'h0, 2'd0);
		send_request(REQ_SET, 64'sd5, 64'h1234_5678_9ABC_DEF0, 2'd1);
		send_request(REQ_SET, 64'sd5, 64'h0FED_CBA9_8765_4321, 2'd2);
		send_request(REQ_SET, -64'sd1, 64'hAAAA_5555_AAAA_5555, 2'd1);
		send_request(2'd3, 64'sd5, 64'h1, 2'd1);
		send_request(REQ_GET, KEY_MAX, '0, 2'd3);
		// search over entries still in arrival order
		set_mode(1'b1);
		send_request(REQ_GET, KEY_MIN, '0, 2'd0);
		send_request(REQ_GET, 64'sd5, '0, 2'd2);
		send_request(REQ_SET, 64'sd0, 64'h5555_AAAA_5555_AAAA, 2'd2);
		send_request(REQ_GET, 64'sd7, '0, 2'd1);
		send_request(2'd3, KEY_MIN, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3);
		send_request(REQ_SORT, 64'sd0, '0, 2'd0);
		send_request(REQ_GET, KEY_MAX, '0, 2'd0);
		send_request(REQ_GET, 64'sd5, '0, 2'd1);
		send_request(REQ_SET, KEY_MIN, 64'hDEAD_BEEF_0000_0001, 2'd1);
		send_request(REQ_GET, KEY_MIN, '0, 2'd1);
		send_request(REQ_SET, 64'sd3, 64'h1, 2'd0);

		for (ph = 0; ph < 5; ph++) begin
			set_mode(ph[0] ? 1'b0 : 1'b1);
			for (int n = 0; n < 350; n++) begin
				if (n % 100 == 0)
					no_idle = ($urandom_range(0, 2) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 48)
					rt = REQ_SET;
				else if (pick < 96)
					rt = REQ_GET;
				else if (pick < 98)
					rt = REQ_SORT;
				else
					rt = 2'd3;
				if ($urandom_range(0, 1))
					k = key_pool[$urandom_range(0, 47)];
				else
					k = $signed({$urandom, $urandom});
				send_request(rt, k, {$urandom, $urandom}, 2'($urandom_range(0, 3)));
			end
		end
		no_idle = 1'b0;
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_key_value_table verification clean");
		else
			$display("sorted_key_value_table verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/skvt_pkg.sv
src/skvt_datapath.sv
src/skvt_ctrl.sv
src/sorted_key_value_table.sv
tb/sv/skvt_checker.sv
tb/sv/tb_sorted_key_value_table.sv
